### hw/rtl/msx_pkg.sv
package msx_pkg;

  // channel payloads
  typedef struct packed {
    logic [31:0] instr_word;
  } in_t;

  typedef struct packed {
    logic [31:0] start_pc;
  } cfg_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        syscall_pending;
    logic [31:0] syscall_code;
    logic [31:0] syscall_arg;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
  } res_t;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_MUL     = 6'd28;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  // special function codes
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_SLT     = 6'd42;

  // regimm rt codes
  localparam logic [4:0] RT_BLTZ = 5'd0;
  localparam logic [4:0] RT_BGEZ = 5'd1;

  // register numbers
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_V0   = 5'd2;
  localparam logic [4:0] REG_A0   = 5'd4;
  localparam logic [4:0] REG_RA   = 5'd31;

  localparam logic [31:0] EXIT_CODE = 32'd10;

  typedef enum logic [1:0] {
    SZ_NONE,
    SZ_BYTE,
    SZ_HALF,
    SZ_WORD
  } mem_size_e;

  // decoded and executed instruction
  typedef struct packed {
    logic [31:0] npc;
    logic        halt;
    logic        pend;
    logic [31:0] scode;
    logic [31:0] sarg;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    mem_size_e   ld_size;
    mem_size_e   st_size;
    logic [31:0] addr;
    logic [31:0] st_data;
  } exec_t;

endpackage

### hw/rtl/msx_stream_if.sv
interface msx_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/msx_ram.sv
module msx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-edge write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### hw/rtl/msx_exec.sv
module msx_exec
  import msx_pkg::*;
(
  input  logic [31:0] instr_i,
  input  logic [31:0] pc_i,
  input  logic [31:0] vs_i,
  input  logic [31:0] vt_i,
  input  logic [31:0] v0_i,
  input  logic [31:0] a0_i,
  output exec_t       ex_o
);
  logic [5:0]  op, fn;
  logic [4:0]  sh, rd, rt, rs;
  logic [15:0] imm;
  logic [31:0] simm, zimm, seq_pc, br_pc, jtgt, prod;
  logic        neg, lt_t, lt_i;
  logic        wr_req;
  logic [4:0]  widx;
  logic [31:0] wval;

  assign op     = instr_i[31:26];
  assign rs     = instr_i[25:21];
  assign rt     = instr_i[20:16];
  assign rd     = instr_i[15:11];
  assign sh     = instr_i[10:6];
  assign fn     = instr_i[5:0];
  assign imm    = instr_i[15:0];
  assign simm   = {{16{imm[15]}}, imm};
  assign zimm   = {16'h0000, imm};
  assign seq_pc = pc_i + 32'd4;
  assign br_pc  = pc_i + {simm[29:0], 2'b00};
  assign jtgt   = {pc_i[31:28], instr_i[25:0], 2'b00};
  assign prod   = vs_i * vt_i;
  assign neg    = vs_i[31];
  assign lt_t   = $signed(vs_i) < $signed(vt_i);
  assign lt_i   = $signed(vs_i) < $signed(simm);

  always_comb begin
    wr_req        = 1'b0;
    widx          = rd;
    wval          = '0;
    ex_o          = '0;
    ex_o.npc      = seq_pc;
    ex_o.ld_size  = SZ_NONE;
    ex_o.st_size  = SZ_NONE;
    ex_o.addr     = vs_i + simm;
    ex_o.st_data  = vt_i;
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_SLL:  begin wr_req = 1'b1; wval = vt_i << sh; end
          FN_SRL:  begin wr_req = 1'b1; wval = vt_i >> sh; end
          FN_SLLV: begin wr_req = 1'b1; wval = vt_i << vs_i[4:0]; end
          FN_SRLV: begin wr_req = 1'b1; wval = vt_i >> vs_i[4:0]; end
          FN_JR:   ex_o.npc = vs_i;
          FN_SYSCALL: begin
            if (v0_i == EXIT_CODE) begin
              ex_o.halt = 1'b1;
              ex_o.npc  = pc_i;
            end else begin
              ex_o.pend  = 1'b1;
              ex_o.scode = v0_i;
              ex_o.sarg  = a0_i;
            end
          end
          FN_ADD:  begin wr_req = 1'b1; wval = vs_i + vt_i; end
          FN_SUB:  begin wr_req = 1'b1; wval = vs_i - vt_i; end
          FN_AND:  begin wr_req = 1'b1; wval = vs_i & vt_i; end
          FN_OR:   begin wr_req = 1'b1; wval = vs_i | vt_i; end
          FN_XOR:  begin wr_req = 1'b1; wval = vs_i ^ vt_i; end
          FN_SLT:  begin wr_req = 1'b1; wval = {31'd0, lt_t}; end
          default: ;
        endcase
      end
      OP_REGIMM: begin
        if ((rt == RT_BLTZ && neg) || (rt == RT_BGEZ && !neg)) ex_o.npc = br_pc;
      end
      OP_J:    ex_o.npc = jtgt;
      OP_JAL:  begin
        wr_req   = 1'b1;
        widx     = REG_RA;
        wval     = seq_pc;
        ex_o.npc = jtgt;
      end
      OP_BEQ:  if (vs_i == vt_i) ex_o.npc = br_pc;
      OP_BNE:  if (vs_i != vt_i) ex_o.npc = br_pc;
      OP_BLEZ: if (neg || vs_i == 32'd0) ex_o.npc = br_pc;
      OP_BGTZ: if (!neg && vs_i != 32'd0) ex_o.npc = br_pc;
      OP_ADDI: begin wr_req = 1'b1; widx = rt; wval = vs_i + simm; end
      OP_SLTI: begin wr_req = 1'b1; widx = rt; wval = {31'd0, lt_i}; end
      OP_ANDI: begin wr_req = 1'b1; widx = rt; wval = vs_i & zimm; end
      OP_ORI:  begin wr_req = 1'b1; widx = rt; wval = vs_i | zimm; end
      OP_XORI: begin wr_req = 1'b1; widx = rt; wval = vs_i ^ zimm; end
      OP_LUI:  begin wr_req = 1'b1; widx = rt; wval = {imm, 16'h0000}; end
      OP_MUL:  begin wr_req = 1'b1; wval = prod; end
      OP_LB:   begin wr_req = 1'b1; widx = rt; ex_o.ld_size = SZ_BYTE; end
      OP_LH:   begin wr_req = 1'b1; widx = rt; ex_o.ld_size = SZ_HALF; end
      OP_LW:   begin wr_req = 1'b1; widx = rt; ex_o.ld_size = SZ_WORD; end
      OP_SB:   ex_o.st_size = SZ_BYTE;
      OP_SH:   ex_o.st_size = SZ_HALF;
      OP_SW:   ex_o.st_size = SZ_WORD;
      default: ;
    endcase
    // register zero drops the write entirely
    ex_o.wr   = wr_req && (widx != REG_ZERO);
    ex_o.widx = ex_o.wr ? widx : REG_ZERO;
    ex_o.wval = ex_o.wr ? wval : '0;
  end
endmodule

### hw/rtl/mips_subset_execute_top.sv
// a result is offered from the output register once its instruction has passed stage 1 and stage 2
// throughput: one instruction per cycle unless res_o stalls or the clear sweep runs; set by the
//   register file and data memory ports (register read on accept, memory access one stage later)
// reset: pc loads 0, registers read zero, and the data memory is cleared by a sweep over
//   all MEM_BYTES/4 rows during which no instruction is accepted
module mips_subset_execute_top
  import msx_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  msx_stream_if.sink   in_i,
  msx_stream_if.sink   cfg_i,
  msx_stream_if.source res_o
);
  localparam int AW   = $clog2(MEM_BYTES);
  localparam int ROWS = MEM_BYTES / 4;
  localparam int RW   = AW - 2;

  // pipeline control
  logic adv, in_fire, cfg_fire;
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic clr_busy_q;
  logic [RW-1:0] clr_cnt_q;

  // stage registers
  logic [31:0] s1_instr_q;
  logic        s1_rs_ok_q, s1_rt_ok_q;
  exec_t       s2_ex_q;
  logic [1:0]  s2_off_q;
  res_t        res_q;

  // architectural state kept in flops
  logic [31:0] pc_q, v0_q, a0_q;
  logic [31:0] rf_valid_q;

  // last register write, covers the read-old edge of the register rams
  logic        w_valid_q;
  logic [4:0]  w_idx_q;
  logic [31:0] w_val_q;

  logic [31:0] rf_a_rdata, rf_b_rdata;
  logic [4:0]  rs, rt, in_rs, in_rt;
  logic [31:0] vs, vt, v0, a0;
  exec_t       ex;
  logic [31:0] s2_wval, ld_raw, ld_val;
  logic        rf_we;
  logic [7:0]  lane_rdata [4];

  // stall everything only when a finished result is still waiting; input is also held off during the clear sweep
  assign adv      = !out_valid_q || res_o.ready;
  assign in_i.ready = adv && !clr_busy_q;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign in_rs = in_i.data.instr_word[25:21];
  assign in_rt = in_i.data.instr_word[20:16];
  assign rs    = s1_instr_q[25:21];
  assign rt    = s1_instr_q[20:16];

  assign rf_we = adv && s2_valid_q && s2_ex_q.wr;

  // register file: two copies for the two read ports
  msx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_ex_q.widx),
    .wdata_i (s2_wval),
    .re_i    (adv),
    .raddr_i (in_rs),
    .rdata_o (rf_a_rdata)
  );

  msx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_ex_q.widx),
    .wdata_i (s2_wval),
    .re_i    (adv),
    .raddr_i (in_rt),
    .rdata_o (rf_b_rdata)
  );

  // operand forwarding: stage 2 result first, then the last write, then the ram
  always_comb begin
    if (s2_valid_q && s2_ex_q.wr && s2_ex_q.widx == rs) begin
      vs = s2_wval;
    end else if (w_valid_q && w_idx_q == rs) begin
      vs = w_val_q;
    end else begin
      vs = s1_rs_ok_q ? rf_a_rdata : '0;
    end
    if (s2_valid_q && s2_ex_q.wr && s2_ex_q.widx == rt) begin
      vt = s2_wval;
    end else if (w_valid_q && w_idx_q == rt) begin
      vt = w_val_q;
    end else begin
      vt = s1_rt_ok_q ? rf_b_rdata : '0;
    end
    // v0 and a0 shadows are current except for the write still in stage 2
    v0 = (s2_valid_q && s2_ex_q.wr && s2_ex_q.widx == REG_V0) ? s2_wval : v0_q;
    a0 = (s2_valid_q && s2_ex_q.wr && s2_ex_q.widx == REG_A0) ? s2_wval : a0_q;
  end

  msx_exec u_exec (
    .instr_i (s1_instr_q),
    .pc_i    (pc_q),
    .vs_i    (vs),
    .vt_i    (vt),
    .v0_i    (v0),
    .a0_i    (a0),
    .ex_o    (ex)
  );

  // data memory: four byte lanes, lane k holds the bytes whose address is k mod 4
  logic [AW-1:0] ba;
  logic [RW-1:0] base_row;
  logic [1:0]    off;
  logic [2:0]    st_cnt;

  assign ba       = ex.addr[AW-1:0];
  assign base_row = ba[AW-1:2];
  assign off      = ba[1:0];

  always_comb begin
    case (ex.st_size)
      SZ_BYTE: st_cnt = 3'd1;
      SZ_HALF: st_cnt = 3'd2;
      SZ_WORD: st_cnt = 3'd4;
      default: st_cnt = 3'd0;
    endcase
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam logic [1:0] LANE = 2'(l);
    logic [RW-1:0] row;
    logic [1:0]    bidx;
    logic          st_we, we;
    logic [RW-1:0] waddr;
    logic [7:0]    wdata;

    // lanes below the start offset belong to the next row, wrapping at the end
    assign row   = base_row + RW'(LANE < off);
    assign bidx  = LANE - off;
    assign st_we = adv && s1_valid_q && ({1'b0, bidx} < st_cnt);
    assign we    = clr_busy_q || st_we;
    assign waddr = clr_busy_q ? clr_cnt_q : row;
    assign wdata = clr_busy_q ? 8'h00 : 8'(ex.st_data >> {bidx, 3'b000});

    msx_ram #(.WIDTH(8), .DEPTH(ROWS)) u_mem (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (adv),
      .raddr_i (row),
      .rdata_o (lane_rdata[l])
    );
  end

  // load data: byte i of the access sits in lane (offset + i) mod 4
  assign ld_raw = {lane_rdata[2'(s2_off_q + 2'd3)], lane_rdata[2'(s2_off_q + 2'd2)],
                   lane_rdata[2'(s2_off_q + 2'd1)], lane_rdata[s2_off_q]};

  always_comb begin
    case (s2_ex_q.ld_size)
      SZ_BYTE: ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
      SZ_HALF: ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
      default: ld_val = ld_raw;
    endcase
  end

  assign s2_wval = (s2_ex_q.ld_size != SZ_NONE && s2_ex_q.wr) ? ld_val : s2_ex_q.wval;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      w_valid_q   <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      pc_q        <= '0;
      v0_q        <= '0;
      a0_q        <= '0;
      rf_valid_q  <= '0;
    end else begin
      // memory clearing sweep after reset
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + RW'(1);
        if (clr_cnt_q == RW'(ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (adv) begin
        s1_valid_q  <= in_fire;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
        w_valid_q   <= s2_valid_q && s2_ex_q.wr;
      end
      // a start_pc write also reloads the program counter
      if (cfg_fire) begin
        pc_q <= cfg_i.data.start_pc;
      end else if (adv && s1_valid_q) begin
        pc_q <= ex.npc;
      end
      if (rf_we) begin
        rf_valid_q[s2_ex_q.widx] <= 1'b1;
        if (s2_ex_q.widx == REG_V0) v0_q <= s2_wval;
        if (s2_ex_q.widx == REG_A0) a0_q <= s2_wval;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_instr_q <= in_i.data.instr_word;
      s1_rs_ok_q <= rf_valid_q[in_rs];
      s1_rt_ok_q <= rf_valid_q[in_rt];
      s2_ex_q    <= ex;
      s2_off_q   <= off;
      w_idx_q    <= s2_ex_q.widx;
      w_val_q    <= s2_wval;
      res_q.next_pc         <= s2_ex_q.npc;
      res_q.halted          <= s2_ex_q.halt;
      res_q.syscall_pending <= s2_ex_q.pend;
      res_q.syscall_code    <= s2_ex_q.scode;
      res_q.syscall_arg     <= s2_ex_q.sarg;
      res_q.reg_written     <= s2_ex_q.wr;
      res_q.reg_index       <= s2_ex_q.widx;
      res_q.reg_value       <= s2_wval;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;
endmodule
